// File: rtl/mlsau_pkg.sv
package mlsau_pkg;

    typedef enum logic [3:0] {
        FN_LB  = 4'd0,
        FN_LBU = 4'd1,
        FN_LH  = 4'd2,
        FN_LHU = 4'd3,
        FN_LW  = 4'd4,
        FN_LWL = 4'd5,
        FN_LWR = 4'd6,
        FN_SB  = 4'd7,
        FN_SH  = 4'd8,
        FN_SW  = 4'd9,
        FN_SWL = 4'd10,
        FN_SWR = 4'd11,
        FN_LUI = 4'd12,
        FN_ORI = 4'd13
    } t_func;

    typedef struct packed {
        logic        addr_used;
        logic        mem_write;
        logic [3:0]  byte_enable;
        logic [31:0] store_data;
        logic        reg_write;
        logic [31:0] wb_value;
    } t_lane_res;

endpackage

// File: rtl/mlsau_lane.sv
module mlsau_lane
    import mlsau_pkg::*;
(
    input  logic [3:0]  i_func,
    input  logic [1:0]  i_offset,
    input  logic [31:0] i_rt_value,
    input  logic [31:0] i_mem_word,
    input  logic [31:0] i_alu_value,
    output t_lane_res   o_res
);

    logic [7:0]  w_byte;
    logic [15:0] w_half;
    logic [31:0] w_lwl;
    logic [31:0] w_lwr;
    logic [31:0] w_swl_data;
    logic [31:0] w_swr_data;
    logic [3:0]  w_swl_be;
    logic [3:0]  w_swr_be;

    always_comb begin
        case (i_offset)
            2'd0: begin
                w_byte     = i_mem_word[7:0];
                w_lwl      = {i_mem_word[7:0], i_rt_value[23:0]};
                w_lwr      = i_mem_word;
                w_swl_data = {24'd0, i_rt_value[31:24]};
                w_swr_data = i_rt_value;
                w_swl_be   = 4'b0001;
                w_swr_be   = 4'b1111;
            end
            2'd1: begin
                w_byte     = i_mem_word[15:8];
                w_lwl      = {i_mem_word[15:0], i_rt_value[15:0]};
                w_lwr      = {i_rt_value[31:24], i_mem_word[31:8]};
                w_swl_data = {16'd0, i_rt_value[31:16]};
                w_swr_data = {i_rt_value[23:0], 8'd0};
                w_swl_be   = 4'b0011;
                w_swr_be   = 4'b1110;
            end
            2'd2: begin
                w_byte     = i_mem_word[23:16];
                w_lwl      = {i_mem_word[23:0], i_rt_value[7:0]};
                w_lwr      = {i_rt_value[31:16], i_mem_word[31:16]};
                w_swl_data = {8'd0, i_rt_value[31:8]};
                w_swr_data = {i_rt_value[15:0], 16'd0};
                w_swl_be   = 4'b0111;
                w_swr_be   = 4'b1100;
            end
            default: begin
                w_byte     = i_mem_word[31:24];
                w_lwl      = i_mem_word;
                w_lwr      = {i_rt_value[31:8], i_mem_word[31:24]};
                w_swl_data = i_rt_value;
                w_swr_data = {i_rt_value[7:0], 24'd0};
                w_swl_be   = 4'b1111;
                w_swr_be   = 4'b1000;
            end
        endcase
    end

    assign w_half = i_offset[1] ? i_mem_word[31:16] : i_mem_word[15:0];

    always_comb begin
        o_res = '0;
        case (i_func)
            FN_LB: begin
                o_res.addr_used = 1'b1;
                o_res.reg_write = 1'b1;
                o_res.wb_value  = {{24{w_byte[7]}}, w_byte};
            end
            FN_LBU: begin
                o_res.addr_used = 1'b1;
                o_res.reg_write = 1'b1;
                o_res.wb_value  = {24'd0, w_byte};
            end
            FN_LH: begin
                o_res.addr_used = 1'b1;
                o_res.reg_write = 1'b1;
                o_res.wb_value  = {{16{w_half[15]}}, w_half};
            end
            FN_LHU: begin
                o_res.addr_used = 1'b1;
                o_res.reg_write = 1'b1;
                o_res.wb_value  = {16'd0, w_half};
            end
            FN_LW: begin
                o_res.addr_used = 1'b1;
                o_res.reg_write = 1'b1;
                o_res.wb_value  = i_mem_word;
            end
            FN_LWL: begin
                o_res.addr_used = 1'b1;
                o_res.reg_write = 1'b1;
                o_res.wb_value  = w_lwl;
            end
            FN_LWR: begin
                o_res.addr_used = 1'b1;
                o_res.reg_write = 1'b1;
                o_res.wb_value  = w_lwr;
            end
            FN_SB: begin
                o_res.addr_used   = 1'b1;
                o_res.mem_write   = 1'b1;
                o_res.byte_enable = 4'b0001 << i_offset;
                o_res.store_data  = {24'd0, i_rt_value[7:0]} << {i_offset, 3'b000};
            end
            FN_SH: begin
                o_res.addr_used   = 1'b1;
                o_res.mem_write   = 1'b1;
                o_res.byte_enable = i_offset[1] ? 4'b1100 : 4'b0011;
                o_res.store_data  = i_offset[1] ? {i_rt_value[15:0], 16'd0}
                                                : {16'd0, i_rt_value[15:0]};
            end
            FN_SW: begin
                o_res.addr_used   = 1'b1;
                o_res.mem_write   = 1'b1;
                o_res.byte_enable = 4'b1111;
                o_res.store_data  = i_rt_value;
            end
            FN_SWL: begin
                o_res.addr_used   = 1'b1;
                o_res.mem_write   = 1'b1;
                o_res.byte_enable = w_swl_be;
                o_res.store_data  = w_swl_data;
            end
            FN_SWR: begin
                o_res.addr_used   = 1'b1;
                o_res.mem_write   = 1'b1;
                o_res.byte_enable = w_swr_be;
                o_res.store_data  = w_swr_data;
            end
            FN_LUI, FN_ORI: begin
                o_res.reg_write = 1'b1;
                o_res.wb_value  = i_alu_value;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// File: rtl/mips_load_store_align_unit.sv
// Load/store execute stage of a little-endian MIPS R3000 core.
// The input channel (i_valid, o_ready) carries one instruction per
// transaction: the operation, base and rt register values, the raw
// immediate, the destination index and, for loads, the aligned memory word.
// The output channel (o_valid, i_ready) returns exactly one result per
// transaction: effective and word address, store byte enables and lane data,
// and the register write-back index and value.
// The block is a three-stage pipeline: address add, lane selection, and
// output register. Each result passes the s1, s2 and s3 registers in turn,
// and one transaction can be accepted in every cycle in which o_ready is high.
// Each stage advances when it is empty or when the stage after it advances,
// so a stall on i_ready holds every item in place and bubbles still collapse.
// While o_valid is high and i_ready is low, up to three items are held.
// Reset clears all stage valid bits; no result is pending after reset.
module mips_load_store_align_unit
    import mlsau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_func,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_rt_value,
    input  logic [15:0] i_immediate,
    input  logic [4:0]  i_dest_reg,
    input  logic [31:0] i_mem_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_eff_addr,
    output logic [31:0] o_word_addr,
    output logic        o_mem_write,
    output logic [3:0]  o_byte_enable,
    output logic [31:0] o_store_data,
    output logic        o_reg_write,
    output logic [4:0]  o_wb_reg,
    output logic [31:0] o_wb_value
);

    logic w_en1;
    logic w_en2;
    logic w_en3;

    logic        r_s1_valid;
    logic [3:0]  r_s1_func;
    logic [31:0] r_s1_ea;
    logic [31:0] r_s1_rt;
    logic [31:0] r_s1_mem;
    logic [31:0] r_s1_alu;
    logic [4:0]  r_s1_dreg;
    logic [31:0] n_s1_ea;
    logic [31:0] n_s1_alu;

    logic        r_s2_valid;
    logic [31:0] r_s2_ea;
    logic [4:0]  r_s2_dreg;
    t_lane_res   r_s2_res;
    t_lane_res   n_s2_res;

    logic        r_s3_valid;
    logic [31:0] r_s3_eff_addr;
    logic        r_s3_mem_write;
    logic [3:0]  r_s3_byte_enable;
    logic [31:0] r_s3_store_data;
    logic        r_s3_reg_write;
    logic [4:0]  r_s3_wb_reg;
    logic [31:0] r_s3_wb_value;

    assign w_en3   = !r_s3_valid || i_ready;
    assign w_en2   = !r_s2_valid || w_en3;
    assign w_en1   = !r_s1_valid || w_en2;
    assign o_ready = w_en1;

    assign n_s1_ea  = i_base_value + {{16{i_immediate[15]}}, i_immediate};
    assign n_s1_alu = (i_func == FN_LUI) ? {i_immediate, 16'd0}
                                         : (i_base_value | {16'd0, i_immediate});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_valid <= i_valid;
            end
            if (w_en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_en3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_func <= i_func;
            r_s1_ea   <= n_s1_ea;
            r_s1_rt   <= i_rt_value;
            r_s1_mem  <= i_mem_word;
            r_s1_alu  <= n_s1_alu;
            r_s1_dreg <= i_dest_reg;
        end
    end

    mlsau_lane u_lane (
        .i_func      (r_s1_func),
        .i_offset    (r_s1_ea[1:0]),
        .i_rt_value  (r_s1_rt),
        .i_mem_word  (r_s1_mem),
        .i_alu_value (r_s1_alu),
        .o_res       (n_s2_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_ea   <= r_s1_ea;
            r_s2_dreg <= r_s1_dreg;
            r_s2_res  <= n_s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_eff_addr    <= r_s2_res.addr_used ? r_s2_ea : 32'd0;
            r_s3_mem_write   <= r_s2_res.mem_write;
            r_s3_byte_enable <= r_s2_res.byte_enable;
            r_s3_store_data  <= r_s2_res.store_data;
            r_s3_reg_write   <= r_s2_res.reg_write;
            r_s3_wb_reg      <= r_s2_res.reg_write ? r_s2_dreg : 5'd0;
            r_s3_wb_value    <= r_s2_res.wb_value;
        end
    end

    assign o_valid       = r_s3_valid;
    assign o_eff_addr    = r_s3_eff_addr;
    assign o_word_addr   = {r_s3_eff_addr[31:2], 2'b00};
    assign o_mem_write   = r_s3_mem_write;
    assign o_byte_enable = r_s3_byte_enable;
    assign o_store_data  = r_s3_store_data;
    assign o_reg_write   = r_s3_reg_write;
    assign o_wb_reg      = r_s3_wb_reg;
    assign o_wb_value    = r_s3_wb_value;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_mem_write && o_reg_write))
        else $error("result both writes memory and a register");

    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_mem_write) |-> (o_byte_enable == 4'd0 && o_store_data == 32'd0))
        else $error("store lanes active without a memory write");

    a_wb_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reg_write) |-> (o_wb_value == 32'd0 && o_wb_reg == 5'd0))
        else $error("write-back fields active without a register write");

    a_be_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mem_write) |-> (o_byte_enable != 4'd0))
        else $error("memory write with no byte enabled");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_en2) |=> r_s2_valid)
        else $error("stalled pipeline stage lost its item");
`endif

endmodule
